@@ hw/rtl/s20_pkg.sv @@
// Shared types and constants for the Salsa20 keystream combiner.
package s20_pkg;

  localparam int ROUND_COUNT = 20;
  localparam int DR_COUNT = (ROUND_COUNT + 1) / 2;
  localparam int DR_W = $clog2(DR_COUNT + 1);

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;
  localparam logic [31:0] SHORT_ADJ5 = 32'h02000000;
  localparam logic [31:0] SHORT_ADJ10 = 32'h00000004;

  localparam logic [2:0] REG_KEY0 = 3'd0;
  localparam logic [2:0] REG_KEY1 = 3'd1;
  localparam logic [2:0] REG_KEY2 = 3'd2;
  localparam logic [2:0] REG_KEY3 = 3'd3;
  localparam logic [2:0] REG_LONG = 3'd4;
  localparam logic [2:0] REG_NONCE = 3'd5;

  typedef logic [31:0] word_t;
  typedef word_t [15:0] matrix_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FINAL,
    ST_OUT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;      // load input matrix
    logic dround;    // run one double round
    logic finish;    // feed-forward add into keystream buffer, bump counter
    logic take;      // latch output byte, advance position
    logic cfg_clear; // config write; one to REG_NONCE or below clears counter and position
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic empty;
  } status_t;

  function automatic word_t rotl(word_t v, int s);
    rotl = (v << s) | (v >> (32 - s));
  endfunction

  function automatic matrix_t qr(matrix_t m, int a, int b, int c, int d);
    matrix_t r;
    r = m;
    r[b] = r[b] ^ rotl(r[a] + r[d], 7);
    r[c] = r[c] ^ rotl(r[b] + r[a], 9);
    r[d] = r[d] ^ rotl(r[c] + r[b], 13);
    r[a] = r[a] ^ rotl(r[d] + r[c], 18);
    qr = r;
  endfunction

endpackage

@@ hw/rtl/s20_ctrl.sv @@
// Controller state machine for the Salsa20 keystream combiner.
module s20_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  logic              cfg_write,
  output logic              cfg_ready,
  input  s20_pkg::status_t  status,
  output s20_pkg::cmd_t     cmd
);
  import s20_pkg::*;

  state_t state, state_next;
  logic [DR_W-1:0] rcnt, rcnt_next;
  logic out_valid_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rcnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      rcnt <= rcnt_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    rcnt_next = rcnt;
    cmd = '0;
    // config only while no byte is in the core
    cfg_ready = (state == ST_IDLE);
    cmd.cfg_clear = cfg_write && cfg_ready;
    in_ready = 1'b0;
    out_valid_next = out_valid;
    if (out_valid && out_ready) out_valid_next = 1'b0;
    unique case (state)
      ST_IDLE: begin
        // a config write goes first; the byte is not taken while it is offered
        in_ready = !cfg_write;
        if (in_valid && !cfg_write) begin
          if (status.empty) begin
            cmd.load = 1'b1;
            rcnt_next = '0;
            state_next = ST_ROUND;
          end else begin
            state_next = ST_OUT;
          end
        end
      end
      ST_ROUND: begin
        cmd.dround = 1'b1;
        rcnt_next = rcnt + 1'b1;
        if (rcnt == DR_W'(DR_COUNT - 1)) state_next = ST_FINAL;
      end
      ST_FINAL: begin
        cmd.finish = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.take = 1'b1;
          out_valid_next = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

@@ hw/rtl/s20_dp.sv @@
// Datapath for the Salsa20 keystream combiner: config, core, buffer, output.
module s20_dp (
  input  logic             clk,
  input  logic             rst,
  input  s20_pkg::cmd_t    cmd,
  output s20_pkg::status_t status,
  input  logic             in_take,
  input  logic [7:0]       data_in,
  input  logic [2:0]       cfg_addr,
  input  logic [63:0]      cfg_data,
  output logic [7:0]       data_out
);
  import s20_pkg::*;

  logic [63:0] key0, key1, key2, key3, nonce_r, counter;
  logic        long_key;
  logic [6:0]  left;      // bytes remaining, 0..64
  logic [7:0]  byte_hold;
  matrix_t     in_m, work, ks;
  matrix_t     dr;
  logic [5:0]  pos;
  word_t       ks_word;

  // Input matrix
  always_comb begin
    in_m[0] = SIGMA0;
    in_m[5] = long_key ? SIGMA1 : SIGMA1 - SHORT_ADJ5;
    in_m[10] = long_key ? SIGMA2 : SIGMA2 + SHORT_ADJ10;
    in_m[15] = SIGMA3;
    in_m[1] = key0[31:0];
    in_m[2] = key0[63:32];
    in_m[3] = key1[31:0];
    in_m[4] = key1[63:32];
    in_m[11] = long_key ? key2[31:0] : key0[31:0];
    in_m[12] = long_key ? key2[63:32] : key0[63:32];
    in_m[13] = long_key ? key3[31:0] : key1[31:0];
    in_m[14] = long_key ? key3[63:32] : key1[63:32];
    in_m[6] = nonce_r[31:0];
    in_m[7] = nonce_r[63:32];
    in_m[8] = counter[31:0];
    in_m[9] = counter[63:32];
  end

  // One double round: columns then rows
  always_comb begin
    dr = work;
    dr = qr(dr, 0, 4, 8, 12);
    dr = qr(dr, 5, 9, 13, 1);
    dr = qr(dr, 10, 14, 2, 6);
    dr = qr(dr, 15, 3, 7, 11);
    dr = qr(dr, 0, 1, 2, 3);
    dr = qr(dr, 5, 6, 7, 4);
    dr = qr(dr, 10, 11, 8, 9);
    dr = qr(dr, 15, 12, 13, 14);
  end

  assign pos = 6'(7'd64 - left);
  assign ks_word = ks[pos[5:2]];
  assign status.empty = (left == 7'd0);

  // Config registers and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      key0 <= '0; key1 <= '0; key2 <= '0; key3 <= '0;
      nonce_r <= '0;
      long_key <= 1'b1;
      counter <= '0;
      left <= '0;
    end else begin
      if (cmd.cfg_clear) begin
        case (cfg_addr)
          REG_KEY0:  key0 <= cfg_data;
          REG_KEY1:  key1 <= cfg_data;
          REG_KEY2:  key2 <= cfg_data;
          REG_KEY3:  key3 <= cfg_data;
          REG_LONG:  long_key <= cfg_data[0];
          REG_NONCE: nonce_r <= cfg_data;
          default: ;
        endcase
        if (cfg_addr <= REG_NONCE) begin
          counter <= '0;
          left <= '0;
        end
      end
      if (cmd.finish) begin
        counter <= counter + 64'd1;
        left <= 7'd64;
      end
      if (cmd.take) left <= left - 7'd1;
    end
  end

  // Core state, buffer and output byte
  always_ff @(posedge clk) begin
    if (in_take) byte_hold <= data_in;
    if (cmd.load) work <= in_m;
    else if (cmd.dround) work <= dr;
    if (cmd.finish) begin
      for (int i = 0; i < 16; i++) ks[i] <= work[i] + in_m[i];
    end
    if (cmd.take) data_out <= byte_hold ^ ks_word[8*pos[1:0] +: 8];
  end
endmodule

@@ hw/rtl/salsa20_keystream_xor.sv @@
// Top level of the Salsa20/20 keystream combiner, one byte per word.
//  channel | valid    | ready    | payload
//  input   | in_valid | in_ready | data_in
//  output  | out_valid| out_ready| data_out
//  config  | cfg_valid| cfg_ready| cfg_addr, cfg_data
// A byte from the buffer is accepted while idle, then loaded into the output register.
// A byte that finds the 64-byte buffer empty first runs the core: one double round
// a cycle for the ten double rounds, then the feed-forward add into the buffer.
// Reset is synchronous; the buffer starts empty. A stalled output keeps the
// controller in its output state, next byte held in the datapath, until out_ready.
// Config is taken only while idle, ahead of a byte offered in the same cycle.
module salsa20_keystream_xor (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  data_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_addr,
  input  logic [63:0] cfg_data
);
  import s20_pkg::*;

  cmd_t    cmd;
  status_t status;

  s20_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cfg_write(cfg_valid),
    .cfg_ready(cfg_ready), .status(status), .cmd(cmd)
  );

  s20_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .in_take(in_valid && in_ready), .data_in(data_in),
    .cfg_addr(cfg_addr), .cfg_data(cfg_data), .data_out(data_out)
  );
endmodule
